@@ rtl/assert_macros.svh @@
// Assertion macros shared by the decoder RTL.
// Depends on nothing; SYNTH selects the empty forms for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked on every rising clock edge, off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/ps2sc_pkg.sv @@
// Shared types, scancode constants and the US keymap for the set-1 decoder.
// No dependencies.
package ps2sc_pkg;

  // Set-1 scancode bytes
  localparam logic [7:0] ScPrefixExt = 8'hE0;
  localparam logic [7:0] ScBreakMask = 8'h80;
  localparam logic [7:0] ScLShift    = 8'h2A;
  localparam logic [7:0] ScRShift    = 8'h36;
  localparam logic [7:0] ScCtrl      = 8'h1D;
  localparam logic [7:0] ScAlt       = 8'h38;
  localparam logic [7:0] ScF1        = 8'h3B;
  localparam logic [7:0] ScF8        = 8'h42;
  localparam logic [7:0] ScPgUp      = 8'h49;
  localparam logic [7:0] ScPgDn      = 8'h51;
  localparam logic [7:0] ScUp        = 8'h48;
  localparam logic [7:0] ScDown      = 8'h50;
  localparam logic [7:0] KeymapLen   = 8'd58;

  localparam logic signed [4:0] ScrollPage = 5'sd10;
  localparam logic signed [4:0] ScrollLine = 5'sd1;

  // Command queue between classifier and output stage
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_CHAR    = 2'd1,
    EVT_CONSOLE = 2'd2,
    EVT_SCROLL  = 2'd3
  } evt_kind_e;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic ext;
  } mod_flags_t;

  typedef struct packed {
    evt_kind_e         kind;
    logic [5:0]        key;     // keymap index for character events
    logic              shift;
    logic [2:0]        con;
    logic signed [4:0] scroll;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  // US layout; a zero entry means the key produces no character
  function automatic logic [6:0] keymap(input logic [5:0] idx, input logic shift);
    logic [6:0] p;
    logic [6:0] s;
    p = 7'h00;
    s = 7'h00;
    case (idx)
      6'd1:  begin p = 7'h1B; s = 7'h1B; end
      6'd2:  begin p = 7'h31; s = 7'h21; end
      6'd3:  begin p = 7'h32; s = 7'h40; end
      6'd4:  begin p = 7'h33; s = 7'h23; end
      6'd5:  begin p = 7'h34; s = 7'h24; end
      6'd6:  begin p = 7'h35; s = 7'h25; end
      6'd7:  begin p = 7'h36; s = 7'h5E; end
      6'd8:  begin p = 7'h37; s = 7'h26; end
      6'd9:  begin p = 7'h38; s = 7'h2A; end
      6'd10: begin p = 7'h39; s = 7'h28; end
      6'd11: begin p = 7'h30; s = 7'h29; end
      6'd12: begin p = 7'h2D; s = 7'h5F; end
      6'd13: begin p = 7'h3D; s = 7'h2B; end
      6'd14: begin p = 7'h08; s = 7'h08; end
      6'd15: begin p = 7'h09; s = 7'h09; end
      6'd16: begin p = 7'h71; s = 7'h51; end
      6'd17: begin p = 7'h77; s = 7'h57; end
      6'd18: begin p = 7'h65; s = 7'h45; end
      6'd19: begin p = 7'h72; s = 7'h52; end
      6'd20: begin p = 7'h74; s = 7'h54; end
      6'd21: begin p = 7'h79; s = 7'h59; end
      6'd22: begin p = 7'h75; s = 7'h55; end
      6'd23: begin p = 7'h69; s = 7'h49; end
      6'd24: begin p = 7'h6F; s = 7'h4F; end
      6'd25: begin p = 7'h70; s = 7'h50; end
      6'd26: begin p = 7'h5B; s = 7'h7B; end
      6'd27: begin p = 7'h5D; s = 7'h7D; end
      6'd28: begin p = 7'h0A; s = 7'h0A; end
      6'd30: begin p = 7'h61; s = 7'h41; end
      6'd31: begin p = 7'h73; s = 7'h53; end
      6'd32: begin p = 7'h64; s = 7'h44; end
      6'd33: begin p = 7'h66; s = 7'h46; end
      6'd34: begin p = 7'h67; s = 7'h47; end
      6'd35: begin p = 7'h68; s = 7'h48; end
      6'd36: begin p = 7'h6A; s = 7'h4A; end
      6'd37: begin p = 7'h6B; s = 7'h4B; end
      6'd38: begin p = 7'h6C; s = 7'h4C; end
      6'd39: begin p = 7'h3B; s = 7'h3A; end
      6'd40: begin p = 7'h27; s = 7'h22; end
      6'd41: begin p = 7'h60; s = 7'h7E; end
      6'd43: begin p = 7'h5C; s = 7'h7C; end
      6'd44: begin p = 7'h7A; s = 7'h5A; end
      6'd45: begin p = 7'h78; s = 7'h58; end
      6'd46: begin p = 7'h63; s = 7'h43; end
      6'd47: begin p = 7'h76; s = 7'h56; end
      6'd48: begin p = 7'h62; s = 7'h42; end
      6'd49: begin p = 7'h6E; s = 7'h4E; end
      6'd50: begin p = 7'h6D; s = 7'h4D; end
      6'd51: begin p = 7'h2C; s = 7'h3C; end
      6'd52: begin p = 7'h2E; s = 7'h3E; end
      6'd53: begin p = 7'h2F; s = 7'h3F; end
      6'd55: begin p = 7'h2A; s = 7'h2A; end
      6'd57: begin p = 7'h20; s = 7'h20; end
      default: begin p = 7'h00; s = 7'h00; end
    endcase
    return shift ? s : p;
  endfunction

endpackage

@@ rtl/ps2sc_if.sv @@
// Valid/ready channel interfaces for scancode input and decoded events.
// No dependencies.
interface ps2sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;
  logic       from_aux;
  logic       usb_active;

  modport source (output valid, output scan_byte, output from_aux, output usb_active,
                  input ready);
  modport sink   (input valid, input scan_byte, input from_aux, input usb_active,
                  output ready);
endinterface

interface ps2sc_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [6:0]        char_code;
  logic [2:0]        console_index;
  logic signed [4:0] scroll_lines;

  modport source (output valid, output event_kind, output char_code,
                  output console_index, output scroll_lines, input ready);
  modport sink   (input valid, input event_kind, input char_code,
                  input console_index, input scroll_lines, output ready);
endinterface

@@ rtl/ps2sc_scancode_set1_decoder.sv @@
// Top level of the PS/2 set-1 scancode decoder: classifier, queue, output stage.
// Depends on ps2sc_pkg, ps2sc_if, ps2sc_front, ps2sc_fifo, ps2sc_back.
//
//   port   | dir | transaction content
//   -------+-----+-----------------------------------------------
//   in_i   | in  | scan_byte, from_aux, usb_active
//   out_o  | out | event_kind, char_code, console_index, scroll_lines
//
// One byte accepted per cycle while the queue is not full; each byte gives exactly one result.
// Each result passes from the classifier into the queue, then from the queue into the output reg.
// A stalled output fills the two-entry queue, after which in_i.ready drops.
// Reset clears shift/ctrl/alt/prefix flags and empties the queue.
module ps2_scancode_set1_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  ps2sc_in_if.sink    in_i,
  ps2sc_out_if.source out_o
);
  import ps2sc_pkg::*;

  cmd_req_t push;
  cmd_req_t head;
  logic     q_full;
  logic     pop;

  ps2sc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  ps2sc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  ps2sc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

@@ rtl/ps2sc_front.sv @@
// Front end: accepts scancode bytes, tracks modifier/prefix flags, classifies.
// Depends on ps2sc_pkg and ps2sc_in_if.
module ps2sc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  ps2sc_in_if.sink            in_i,
  input  logic                q_full_i,
  output ps2sc_pkg::cmd_req_t push_o
);
  import ps2sc_pkg::*;

  mod_flags_t flags_q, flags_d;
  cmd_t       cmd;
  logic       accept;
  logic [7:0] b;
  logic [7:0] k;

  assign b      = in_i.scan_byte;
  assign k      = b & ~ScBreakMask;
  assign accept = in_i.valid && !q_full_i;
  assign in_i.ready = !q_full_i;

  always_comb begin
    flags_d    = flags_q;
    cmd.kind   = EVT_NONE;
    cmd.key    = b[5:0];
    cmd.shift  = flags_q.shift;
    cmd.con    = 3'(b - ScF1);
    cmd.scroll = '0;
    if (!in_i.from_aux && !in_i.usb_active) begin
      if (b == ScPrefixExt) begin
        flags_d.ext = 1'b1;
      end else if ((b & ScBreakMask) != '0) begin
        if (k == ScLShift || k == ScRShift) flags_d.shift = 1'b0;
        else if (k == ScCtrl)               flags_d.ctrl  = 1'b0;
        else if (k == ScAlt)                flags_d.alt   = 1'b0;
        flags_d.ext = 1'b0;
      end else if (b == ScLShift || b == ScRShift) begin
        flags_d.shift = 1'b1;
      end else if (b == ScCtrl) begin
        flags_d.ctrl = 1'b1;
      end else if (b == ScAlt) begin
        flags_d.alt = 1'b1;
      end else if (flags_q.ctrl && flags_q.alt && b >= ScF1 && b <= ScF8) begin
        cmd.kind = EVT_CONSOLE;
      end else if (flags_q.ext) begin
        // extended make: only the paging/arrow keys scroll
        flags_d.ext = 1'b0;
        if (b == ScPgUp) begin
          cmd.kind = EVT_SCROLL; cmd.scroll = -ScrollPage;
        end else if (b == ScPgDn) begin
          cmd.kind = EVT_SCROLL; cmd.scroll = ScrollPage;
        end else if (b == ScUp) begin
          cmd.kind = EVT_SCROLL; cmd.scroll = -ScrollLine;
        end else if (b == ScDown) begin
          cmd.kind = EVT_SCROLL; cmd.scroll = ScrollLine;
        end
      end else if (b == ScUp) begin
        cmd.kind = EVT_SCROLL; cmd.scroll = -ScrollLine;
      end else if (b == ScDown) begin
        cmd.kind = EVT_SCROLL; cmd.scroll = ScrollLine;
      end else if (b < KeymapLen) begin
        cmd.kind = EVT_CHAR;
      end
    end
  end

  assign push_o.valid = accept;
  assign push_o.cmd   = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (accept) begin
      flags_q <= flags_d;
    end
  end

endmodule

@@ rtl/ps2sc_fifo.sv @@
// Short command queue between the classifier and the output stage.
// Depends on ps2sc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ps2sc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ps2sc_pkg::cmd_req_t push_i,
  output logic                full_o,
  output ps2sc_pkg::cmd_req_t head_o,
  input  logic                pop_i
);
  import ps2sc_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i.valid && !pop_i)      cnt_d = cnt_q + 1'b1;
    else if (!push_i.valid && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.valid) wptr_q <= wptr_q + 1'b1;
      if (pop_i)        rptr_q <= rptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wptr_q] <= push_i.cmd;
  end

  `ASSERT_CLK(a_cnt_bound, clk_i, rst_ni, cnt_q <= QCntW'(QDepth))
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i.valid && full_o)
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !head_o.valid)

endmodule

@@ rtl/ps2sc_back.sv @@
// Back end: turns queued commands into event results, keymap lookup, output reg.
// Depends on ps2sc_pkg, ps2sc_out_if and assert_macros.svh.
`include "assert_macros.svh"

module ps2sc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ps2sc_pkg::cmd_req_t head_i,
  output logic                pop_o,
  ps2sc_out_if.source         out_o
);
  import ps2sc_pkg::*;

  logic              vld_q;
  evt_kind_e         kind_q, kind_d;
  logic [6:0]        char_q, char_d;
  logic [2:0]        con_q, con_d;
  logic signed [4:0] scroll_q, scroll_d;
  logic [6:0]        ch;

  assign pop_o = head_i.valid && (!vld_q || out_o.ready);
  assign ch    = keymap(head_i.cmd.key, head_i.cmd.shift);

  always_comb begin
    kind_d   = EVT_NONE;
    char_d   = '0;
    con_d    = '0;
    scroll_d = '0;
    unique case (head_i.cmd.kind)
      EVT_CHAR: begin
        if (ch != '0) begin
          kind_d = EVT_CHAR;
          char_d = ch;
        end
      end
      EVT_CONSOLE: begin
        kind_d = EVT_CONSOLE;
        con_d  = head_i.cmd.con;
      end
      EVT_SCROLL: begin
        kind_d   = EVT_SCROLL;
        scroll_d = head_i.cmd.scroll;
      end
      default: kind_d = EVT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (out_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= kind_d;
      char_q   <= char_d;
      con_q    <= con_d;
      scroll_q <= scroll_d;
    end
  end

  assign out_o.valid         = vld_q;
  assign out_o.event_kind    = kind_q;
  assign out_o.char_code     = char_q;
  assign out_o.console_index = con_q;
  assign out_o.scroll_lines  = scroll_q;

  `ASSERT_NEVER(a_no_pop_on_stall, clk_i, rst_ni, vld_q && !out_o.ready && pop_o)

endmodule

@@ tb/sv/ps2_scancode_set1_decoder_tb.sv @@
// Self-checking testbench for the PS/2 set-1 scancode decoder.
// Depends on ps2sc_pkg, ps2sc_if and the ps2_scancode_set1_decoder RTL.
// A directed table runs first, then constrained-free random traffic with idles.
module ps2_scancode_set1_decoder_tb;
  import ps2sc_pkg::*;

  localparam int RAND_ITEMS     = 800;
  localparam int DIR_ROWS       = 30;
  localparam int HOLD_CYCLES    = 150;
  localparam int HOLD_AT_EVENT  = 250;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    evt_kind_e         kind;
    logic [6:0]        chr;
    logic [2:0]        con;
    logic signed [4:0] step;
  } key_event_t;

  typedef struct packed {
    logic [7:0] code;
    logic       aux;
    logic       usb;
    logic       fixed;
    key_event_t ev;
  } stim_row_t;

  localparam key_event_t EV_NONE = '{EVT_NONE, 7'h00, 3'd0, 5'sd0};

  // US layout, unshifted and shifted; zero means no character
  logic [6:0] plain_map [0:57] = '{
    'h00, 'h1B, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36, 'h37, 'h38, 'h39, 'h30, 'h2D, 'h3D, 'h08,
    'h09, 'h71, 'h77, 'h65, 'h72, 'h74, 'h79, 'h75, 'h69, 'h6F, 'h70, 'h5B, 'h5D, 'h0A,
    'h00, 'h61, 'h73, 'h64, 'h66, 'h67, 'h68, 'h6A, 'h6B, 'h6C, 'h3B, 'h27, 'h60,
    'h00, 'h5C, 'h7A, 'h78, 'h63, 'h76, 'h62, 'h6E, 'h6D, 'h2C, 'h2E, 'h2F, 'h00,
    'h2A, 'h00, 'h20
  };
  logic [6:0] shift_map [0:57] = '{
    'h00, 'h1B, 'h21, 'h40, 'h23, 'h24, 'h25, 'h5E, 'h26, 'h2A, 'h28, 'h29, 'h5F, 'h2B, 'h08,
    'h09, 'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49, 'h4F, 'h50, 'h7B, 'h7D, 'h0A,
    'h00, 'h41, 'h53, 'h44, 'h46, 'h47, 'h48, 'h4A, 'h4B, 'h4C, 'h3A, 'h22, 'h7E,
    'h00, 'h7C, 'h5A, 'h58, 'h43, 'h56, 'h42, 'h4E, 'h4D, 'h3C, 'h3E, 'h3F, 'h00,
    'h2A, 'h00, 'h20
  };

  // fixed=1 rows carry their expected event, the rest go through the predictor
  stim_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{8'h1E, 1'b0, 1'b0, 1'b1, '{EVT_CHAR, 7'h61, 3'd0, 5'sd0}},
    '{8'h00, 1'b0, 1'b0, 1'b1, EV_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b1, EV_NONE},
    '{8'h2A, 1'b1, 1'b0, 1'b1, EV_NONE},
    '{8'h2A, 1'b0, 1'b1, 1'b1, EV_NONE},
    '{8'h1E, 1'b0, 1'b0, 1'b1, '{EVT_CHAR, 7'h61, 3'd0, 5'sd0}},
    '{8'h2A, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h1E, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h29, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'hAA, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h1D, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h38, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h3B, 1'b0, 1'b0, 1'b1, '{EVT_CONSOLE, 7'h00, 3'd0, 5'sd0}},
    '{8'h42, 1'b0, 1'b0, 1'b1, '{EVT_CONSOLE, 7'h00, 3'd7, 5'sd0}},
    '{8'h10, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'hE0, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h3C, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h9D, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'hB8, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'hE0, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h49, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'hE0, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h1E, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h48, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'hE0, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h1E, 1'b1, 1'b0, 1'b0, EV_NONE},
    '{8'h9E, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h51, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h39, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{8'h3A, 1'b0, 1'b0, 1'b0, EV_NONE}
  };

  logic clk;
  logic rst_n;

  ps2sc_in_if  in_ch ();
  ps2sc_out_if out_ch ();

  ps2_scancode_set1_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  mod_flags_t held;
  key_event_t expected_events [$];
  int         n_errors;
  int         n_events;
  int         idle_cycles;
  logic       in_quiet;
  logic       out_quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic key_event_t decode_scancode(logic [7:0] code, logic aux, logic usb);
    key_event_t ev;
    logic [6:0] key;
    logic [6:0] ch;
    ev  = EV_NONE;
    key = code[6:0];
    if (aux || usb) return ev;
    if (code == ScPrefixExt) begin
      held.ext = 1'b1;
      return ev;
    end
    if ((code & ScBreakMask) != 8'h00) begin
      if (key == ScLShift[6:0] || key == ScRShift[6:0]) held.shift = 1'b0;
      else if (key == ScCtrl[6:0]) held.ctrl = 1'b0;
      else if (key == ScAlt[6:0]) held.alt = 1'b0;
      held.ext = 1'b0;
      return ev;
    end
    if (code == ScLShift || code == ScRShift) begin
      held.shift = 1'b1;
      return ev;
    end
    if (code == ScCtrl) begin
      held.ctrl = 1'b1;
      return ev;
    end
    if (code == ScAlt) begin
      held.alt = 1'b1;
      return ev;
    end
    // console switch wins over a pending prefix and leaves it pending
    if (held.ctrl && held.alt && code >= ScF1 && code <= ScF8) begin
      ev.kind = EVT_CONSOLE;
      ev.con  = 3'(code - ScF1);
      return ev;
    end
    if (held.ext) begin
      held.ext = 1'b0;
      ev.kind  = EVT_SCROLL;
      case (code)
        ScPgUp:  ev.step = -ScrollPage;
        ScPgDn:  ev.step = ScrollPage;
        ScUp:    ev.step = -ScrollLine;
        ScDown:  ev.step = ScrollLine;
        default: ev = EV_NONE;
      endcase
      return ev;
    end
    if (code == ScUp || code == ScDown) begin
      ev.kind = EVT_SCROLL;
      ev.step = (code == ScUp) ? -ScrollLine : ScrollLine;
      return ev;
    end
    if (code < KeymapLen) begin
      ch = held.shift ? shift_map[code] : plain_map[code];
      if (ch != 7'h00) begin
        ev.kind = EVT_CHAR;
        ev.chr  = ch;
      end
    end
    return ev;
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    logic [7:0] mods [4];
    mods = '{ScLShift, ScRShift, ScCtrl, ScAlt};
    r = $urandom_range(0, 99);
    if (r < 20) return mods[$urandom_range(0, 3)] | ($urandom_range(0, 1) ? ScBreakMask : 8'h00);
    if (r < 30) return ScPrefixExt;
    if (r < 38) return ScF1 + 8'($urandom_range(0, 7));
    if (r < 48) begin
      case ($urandom_range(0, 3))
        0:       return ScPgUp;
        1:       return ScPgDn;
        2:       return ScUp;
        default: return ScDown;
      endcase
    end
    if (r < 75) return 8'($urandom_range(0, 57));
    if (r < 85) return 8'($urandom_range(0, 127)) | ScBreakMask;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(logic [7:0] code, logic aux, logic usb, logic fixed, key_event_t ev);
    int gap;
    key_event_t pred;
    gap = in_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.scan_byte  <= code;
    in_ch.from_aux   <= aux;
    in_ch.usb_active <= usb;
    do @(posedge clk); while (!in_ch.ready);
    pred = decode_scancode(code, aux, usb);
    expected_events.push_back(fixed ? ev : pred);
  endtask

  task automatic check_event(key_event_t got);
    key_event_t exp;
    if (expected_events.size() == 0) begin
      $display("%0t: unexpected event, none expected, got kind %0d chr %h con %0d step %0d",
               $time, got.kind, got.chr, got.con, got.step);
      n_errors++;
      return;
    end
    exp = expected_events.pop_front();
    if (got.kind !== exp.kind) begin
      $display("%0t: event_kind mismatch, expected %0d, actual %0d", $time, exp.kind, got.kind);
      n_errors++;
    end
    if (got.chr !== exp.chr) begin
      $display("%0t: char_code mismatch, expected %h, actual %h", $time, exp.chr, got.chr);
      n_errors++;
    end
    if (got.con !== exp.con) begin
      $display("%0t: console_index mismatch, expected %0d, actual %0d", $time, exp.con, got.con);
      n_errors++;
    end
    if (got.step !== exp.step) begin
      $display("%0t: scroll_lines mismatch, expected %0d, actual %0d", $time, exp.step, got.step);
      n_errors++;
    end
  endtask

  // sink side: random stalls, one long hold-off to back the queue up
  initial begin
    int stall;
    key_event_t got;
    out_ch.ready <= 1'b0;
    out_quiet = 1'b0;
    n_events  = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 10);
      if (n_events == HOLD_AT_EVENT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.kind = evt_kind_e'(out_ch.event_kind);
      got.chr  = out_ch.char_code;
      got.con  = out_ch.console_index;
      got.step = out_ch.scroll_lines;
      check_event(got);
      n_events++;
      if (n_events % 50 == 0) out_quiet = ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int sent;
    logic [7:0] code;
    logic aux;
    logic usb;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.scan_byte  <= 8'h00;
    in_ch.from_aux   <= 1'b0;
    in_ch.usb_active <= 1'b0;
    held        = '0;
    n_errors    = 0;
    idle_cycles = 0;
    in_quiet    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(dir_tab[i].code, dir_tab[i].aux, dir_tab[i].usb, dir_tab[i].fixed, dir_tab[i].ev);

    sent = 0;
    while (sent < RAND_ITEMS - DIR_ROWS) begin
      code = pick_code();
      aux  = ($urandom_range(0, 15) == 0);
      usb  = ($urandom_range(0, 15) == 0);
      send_byte(code, aux, usb, 1'b0, EV_NONE);
      sent++;
      if (sent % 50 == 0) in_quiet = ($urandom_range(0, 2) == 0);
    end
    in_ch.valid <= 1'b0;

    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
